// ===== rtl/bcft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcft_pkg
// Shared types and constants for the block chain file table.
// ----------------------------------------------------------------------------
package bcft_pkg;

    // Storage geometry.
    localparam int STORE_BLOCKS = 4096;
    localparam int FILE_SLOTS   = 16;
    localparam int MAX_RUN      = 16;

    localparam int IDX_W  = $clog2(STORE_BLOCKS);
    localparam int LINK_W = $clog2(STORE_BLOCKS + 1);
    localparam int SLOT_W = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int RUN_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    // Field widths of the command and result beats.
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 16;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 12;
    localparam int ST_W    = 3;
    localparam int BIDX_W  = 12;
    localparam int ADDR_W  = 32;
    localparam int OWNER_W = 17;
    localparam int BLOCK_SHIFT = 9;

    localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(STORE_BLOCKS);
    localparam logic [OWNER_W-1:0] NO_OWNER  = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE = 3'd0,
        FN_OPEN   = 3'd1,
        FN_CLOSE  = 3'd2,
        FN_APPEND = 3'd3,
        FN_REMOVE = 3'd4,
        FN_SEEK   = 3'd5
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOPERM   = 3'd3,
        ST_FULL     = 3'd4,
        ST_EXISTS   = 3'd5,
        ST_RANGE    = 3'd6
    } t_status;

    // Write request into the file slot table.
    typedef struct packed {
        logic               create;
        logic               set_owner;
        logic               set_first;
        logic               clear;
        logic [SLOT_W-1:0]  idx;
        logic [ID_W-1:0]    key;
        logic [OWNER_W-1:0] owner;
        logic [LINK_W-1:0]  first;
    } t_slot_wr;

    // Lookup answer from the file slot table.
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  hit_idx;
        logic               free_ok;
        logic [SLOT_W-1:0]  free_idx;
        logic [OWNER_W-1:0] owner;
        logic [LINK_W-1:0]  first;
    } t_slot_rd;

    // One result beat.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BIDX_W-1:0] index;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_result;

endpackage

// ===== rtl/bcft_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcft_link_mem
// Link table: one next-block entry per storage block, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module bcft_link_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [bcft_pkg::IDX_W-1:0]  i_waddr,
    input  logic [bcft_pkg::LINK_W-1:0] i_wdata,
    input  logic [bcft_pkg::IDX_W-1:0]  i_raddr,
    output logic [bcft_pkg::LINK_W-1:0] o_rdata
);

    logic [bcft_pkg::LINK_W-1:0] r_mem [bcft_pkg::STORE_BLOCKS];
    logic [bcft_pkg::LINK_W-1:0] r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bcft_slot_tbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcft_slot_tbl
// File slot table: identifier, owner and first block per file, with a key
// search and a lowest-free-slot search.
// ----------------------------------------------------------------------------
module bcft_slot_tbl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bcft_pkg::ID_W-1:0]  i_key,
    input  bcft_pkg::t_slot_wr         i_wr,
    output bcft_pkg::t_slot_rd         o_rd
);

    logic [bcft_pkg::FILE_SLOTS-1:0] r_valid;
    logic [bcft_pkg::ID_W-1:0]       r_key   [bcft_pkg::FILE_SLOTS];
    logic [bcft_pkg::OWNER_W-1:0]    r_owner [bcft_pkg::FILE_SLOTS];
    logic [bcft_pkg::LINK_W-1:0]     r_first [bcft_pkg::FILE_SLOTS];

    logic                        hit;
    logic                        free_ok;
    logic [bcft_pkg::SLOT_W-1:0] hit_idx;
    logic [bcft_pkg::SLOT_W-1:0] free_idx;

    // Key match and lowest free slot, both in priority order.
    always_comb begin
        hit      = 1'b0;
        free_ok  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = bcft_pkg::FILE_SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_key[s] == i_key) begin
                hit     = 1'b1;
                hit_idx = bcft_pkg::SLOT_W'(s);
            end
            if (!r_valid[s]) begin
                free_ok  = 1'b1;
                free_idx = bcft_pkg::SLOT_W'(s);
            end
        end
    end

    assign o_rd.hit      = hit;
    assign o_rd.hit_idx  = hit_idx;
    assign o_rd.free_ok  = free_ok;
    assign o_rd.free_idx = free_idx;
    assign o_rd.owner    = r_owner[hit_idx];
    assign o_rd.first    = r_first[hit_idx];

    // Valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.create) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.clear) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    // Slot contents need no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr.create) begin
            r_key[i_wr.idx]   <= i_wr.key;
            r_owner[i_wr.idx] <= bcft_pkg::NO_OWNER;
            r_first[i_wr.idx] <= bcft_pkg::NULL_LINK;
        end
        if (i_wr.set_owner) begin
            r_owner[i_wr.idx] <= i_wr.owner;
        end
        if (i_wr.set_first) begin
            r_first[i_wr.idx] <= i_wr.first;
        end
    end

endmodule

// ===== rtl/block_chain_file_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_chain_file_table
// File allocation by linked block chains: create, open, close, append,
// remove and seek on a small file table over a block link table.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  command   start / busy         i_func, i_caller_id, i_file_id,
//                                 i_block_count, i_position
//  result    o_strobe (1 cycle)   o_status, o_block_index, o_block_address,
//                                 o_last
//  config    i_cfg_we             i_cfg_data (storage base)
//
// After reset the link table is initialised one entry a cycle, with busy held
// high. After a command is taken busy stays high through the lookup, the cut of
// an append run of n blocks from the free chain, the walk of the file chain to
// its tail (append, remove) and the walk of a seek to position p; append then
// gives its n result beats one a cycle.
// The receiver cannot stall result beats.
// ----------------------------------------------------------------------------
module block_chain_file_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_caller_id,
    input  logic [15:0] i_file_id,
    input  logic [4:0]  i_block_count,
    input  logic [11:0] i_position,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [11:0] o_block_index,
    output logic [31:0] o_block_address,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W  = bcft_pkg::IDX_W;
    localparam int LINK_W = bcft_pkg::LINK_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_A_CHK, S_A_WAIT, S_T_CHK, S_T_WAIT,
        S_S_CHK, S_S_WAIT, S_EMIT
    } t_state;

    t_state                           r_state;
    bcft_pkg::t_func                  r_func;
    logic [bcft_pkg::ID_W-1:0]        r_caller;
    logic [bcft_pkg::ID_W-1:0]        r_key;
    logic [bcft_pkg::CNT_W-1:0]       r_count;
    logic [bcft_pkg::POS_W-1:0]       r_pos;
    logic [bcft_pkg::ADDR_W-1:0]      r_base;
    logic [LINK_W-1:0]                r_free_head;
    logic [LINK_W-1:0]                r_first;
    logic [bcft_pkg::SLOT_W-1:0]      r_sidx;
    logic [LINK_W-1:0]                r_b;
    logic [IDX_W-1:0]                 r_lastb;
    logic [IDX_W-1:0]                 r_t;
    logic [bcft_pkg::POS_W-1:0]       r_i;
    logic [bcft_pkg::RUN_W-1:0]       r_k;
    logic [IDX_W-1:0]                 r_buf [bcft_pkg::MAX_RUN];
    logic [IDX_W-1:0]                 r_clr;
    logic                             r_strobe;
    bcft_pkg::t_result                r_res;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [LINK_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [LINK_W-1:0]    mem_rdata;
    bcft_pkg::t_slot_wr   slot_wr;
    bcft_pkg::t_slot_rd   slot_rd;
    logic                 perm;
    logic                 run_done;
    logic                 tail_found;

    // Status-only result beat.
    function automatic bcft_pkg::t_result status_beat(input bcft_pkg::t_status st);
        bcft_pkg::t_result res;
        res.status = st;
        res.index  = '0;
        res.addr   = '0;
        res.last   = 1'b1;
        return res;
    endfunction

    // Result beat that reports a block and its byte address.
    function automatic bcft_pkg::t_result block_beat(
        input logic [bcft_pkg::ADDR_W-1:0] base,
        input logic [IDX_W-1:0]            blk,
        input logic                        last
    );
        bcft_pkg::t_result res;
        res.status = bcft_pkg::ST_OK;
        res.index  = bcft_pkg::BIDX_W'(blk);
        res.addr   = base + (bcft_pkg::ADDR_W'(blk) << bcft_pkg::BLOCK_SHIFT);
        res.last   = last;
        return res;
    endfunction

    bcft_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bcft_slot_tbl u_slot_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_key),
        .i_wr    (slot_wr),
        .o_rd    (slot_rd)
    );

    assign perm = (slot_rd.owner == bcft_pkg::NO_OWNER) ||
                  (slot_rd.owner == {1'b0, r_caller});
    assign run_done   = (r_i == bcft_pkg::POS_W'(r_count));
    assign tail_found = (mem_rdata >= bcft_pkg::NULL_LINK);

    // Link table port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = LINK_W'(r_clr) + LINK_W'(1);
        mem_raddr = r_b[IDX_W-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_A_CHK: begin
                if (run_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_lastb;
                    mem_wdata = bcft_pkg::NULL_LINK;
                end
            end
            S_T_CHK: begin
                mem_raddr = r_t;
            end
            S_T_WAIT: begin
                mem_waddr = r_t;
                mem_wdata = (r_func == bcft_pkg::FN_APPEND) ?
                            LINK_W'(r_buf[0]) : r_free_head;
                mem_we    = tail_found;
            end
            default: begin
            end
        endcase
    end

    // Slot table write control.
    always_comb begin
        slot_wr           = '0;
        slot_wr.idx       = r_sidx;
        slot_wr.key       = r_key;
        slot_wr.owner     = (r_func == bcft_pkg::FN_OPEN) ?
                            {1'b0, r_caller} : bcft_pkg::NO_OWNER;
        slot_wr.first     = LINK_W'(r_buf[0]);
        case (r_state)
            S_LOOKUP: begin
                slot_wr.idx = slot_rd.hit_idx;
                case (r_func)
                    bcft_pkg::FN_CREATE: begin
                        slot_wr.idx    = slot_rd.free_idx;
                        slot_wr.create = !slot_rd.hit && slot_rd.free_ok;
                    end
                    bcft_pkg::FN_OPEN, bcft_pkg::FN_CLOSE: begin
                        slot_wr.set_owner = slot_rd.hit && perm;
                    end
                    bcft_pkg::FN_REMOVE: begin
                        slot_wr.clear = slot_rd.hit && perm &&
                                        (slot_rd.first >= bcft_pkg::NULL_LINK);
                    end
                    default: begin
                    end
                endcase
            end
            S_A_CHK: begin
                slot_wr.set_first = run_done && (r_first >= bcft_pkg::NULL_LINK);
            end
            S_T_WAIT: begin
                slot_wr.clear = tail_found && (r_func == bcft_pkg::FN_REMOVE);
            end
            default: begin
            end
        endcase
    end

    // Sequencer: state, walk registers and the registered result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free_head <= '0;
            r_base      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(bcft_pkg::STORE_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_func   <= bcft_pkg::t_func'(i_func);
                        r_caller <= i_caller_id;
                        r_key    <= i_file_id;
                        r_count  <= i_block_count;
                        r_pos    <= i_position;
                        if (i_func <= bcft_pkg::FN_SEEK) begin
                            r_state <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP: begin
                    r_sidx  <= slot_rd.hit_idx;
                    r_first <= slot_rd.first;
                    r_i     <= '0;
                    r_k     <= '0;
                    r_state <= S_IDLE;
                    if (r_func == bcft_pkg::FN_CREATE) begin
                        r_strobe <= 1'b1;
                        if (slot_rd.hit) begin
                            r_res <= status_beat(bcft_pkg::ST_EXISTS);
                        end else if (!slot_rd.free_ok) begin
                            r_res <= status_beat(bcft_pkg::ST_FULL);
                        end else begin
                            r_res <= status_beat(bcft_pkg::ST_OK);
                        end
                    end else if (!slot_rd.hit) begin
                        r_strobe <= 1'b1;
                        r_res    <= status_beat(bcft_pkg::ST_NOTFOUND);
                    end else if (!perm) begin
                        r_strobe <= 1'b1;
                        r_res    <= status_beat(bcft_pkg::ST_NOPERM);
                    end else begin
                        case (r_func)
                            bcft_pkg::FN_APPEND: begin
                                if (r_count == '0 ||
                                    r_count > bcft_pkg::CNT_W'(bcft_pkg::MAX_RUN)) begin
                                    r_strobe <= 1'b1;
                                    r_res    <= status_beat(bcft_pkg::ST_NOSPACE);
                                end else begin
                                    r_b     <= r_free_head;
                                    r_state <= S_A_CHK;
                                end
                            end
                            bcft_pkg::FN_REMOVE: begin
                                if (slot_rd.first < bcft_pkg::NULL_LINK) begin
                                    r_t     <= slot_rd.first[IDX_W-1:0];
                                    r_state <= S_T_CHK;
                                end else begin
                                    r_strobe <= 1'b1;
                                    r_res    <= status_beat(bcft_pkg::ST_OK);
                                end
                            end
                            bcft_pkg::FN_SEEK: begin
                                r_b     <= slot_rd.first;
                                r_state <= S_S_CHK;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_res    <= status_beat(bcft_pkg::ST_OK);
                            end
                        endcase
                    end
                end
                // Cut the run from the free chain, reading one link through S_A_CHK and S_A_WAIT.
                S_A_CHK: begin
                    if (run_done) begin
                        r_free_head <= r_b;
                        if (r_first >= bcft_pkg::NULL_LINK) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_t     <= r_first[IDX_W-1:0];
                            r_state <= S_T_CHK;
                        end
                    end else if (r_b >= bcft_pkg::NULL_LINK) begin
                        r_strobe <= 1'b1;
                        r_res    <= status_beat(bcft_pkg::ST_NOSPACE);
                        r_state  <= S_IDLE;
                    end else begin
                        r_buf[r_i[bcft_pkg::RUN_W-1:0]] <= r_b[IDX_W-1:0];
                        r_lastb <= r_b[IDX_W-1:0];
                        r_state <= S_A_WAIT;
                    end
                end
                S_A_WAIT: begin
                    r_b     <= mem_rdata;
                    r_i     <= r_i + bcft_pkg::POS_W'(1);
                    r_state <= S_A_CHK;
                end
                // Walk to the file chain tail; link run (append) or free chain (remove) to it.
                S_T_CHK: begin
                    r_state <= S_T_WAIT;
                end
                S_T_WAIT: begin
                    if (tail_found) begin
                        if (r_func == bcft_pkg::FN_APPEND) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_free_head <= r_first;
                            r_strobe    <= 1'b1;
                            r_res       <= status_beat(bcft_pkg::ST_OK);
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_t     <= mem_rdata[IDX_W-1:0];
                        r_state <= S_T_CHK;
                    end
                end
                // Follow the chain to the requested position.
                S_S_CHK: begin
                    if (r_b >= bcft_pkg::NULL_LINK) begin
                        r_strobe <= 1'b1;
                        r_res    <= status_beat(bcft_pkg::ST_RANGE);
                        r_state  <= S_IDLE;
                    end else if (r_i == r_pos) begin
                        r_strobe <= 1'b1;
                        r_res    <= block_beat(r_base, r_b[IDX_W-1:0], 1'b1);
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_S_WAIT;
                    end
                end
                S_S_WAIT: begin
                    r_b     <= mem_rdata;
                    r_i     <= r_i + bcft_pkg::POS_W'(1);
                    r_state <= S_S_CHK;
                end
                // One result beat per appended block.
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_k      <= r_k + bcft_pkg::RUN_W'(1);
                    if (bcft_pkg::CNT_W'(r_k) + bcft_pkg::CNT_W'(1) == r_count) begin
                        r_res   <= block_beat(r_base, r_buf[r_k], 1'b1);
                        r_state <= S_IDLE;
                    end else begin
                        r_res   <= block_beat(r_base, r_buf[r_k], 1'b0);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_res.status;
    assign o_block_index   = r_res.index;
    assign o_block_address = r_res.addr;
    assign o_last          = r_res.last;

endmodule
